@@ sv/assert_macros.svh @@
// Assertion macros shared by the bracket balance checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define ASSERT_AT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

@@ sv/bbc_pkg.sv @@
// Package with types, codes and the byte classifier of the bracket balance checker.
package bbc_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] CH_LROUND  = 8'h28;
  localparam logic [7:0] CH_RROUND  = 8'h29;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_LCURLY  = 8'h7B;
  localparam logic [7:0] CH_RCURLY  = 8'h7D;

  localparam logic [1:0] KIND_ROUND  = 2'd0;
  localparam logic [1:0] KIND_SQUARE = 2'd1;
  localparam logic [1:0] KIND_CURLY  = 2'd2;

  localparam logic [1:0] OP_NOP  = 2'd0;
  localparam logic [1:0] OP_PUSH = 2'd1;
  localparam logic [1:0] OP_POP  = 2'd2;
  localparam logic [1:0] OP_END  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MISMATCH = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_UNCLOSED = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  typedef struct packed {
    logic       mode;
    logic [7:0] character;
  } req_t;

  typedef struct packed {
    logic       expression_valid;
    logic [2:0] status;
  } rsp_t;

  typedef struct packed {
    logic [1:0] code;
    logic [1:0] kind;
  } op_t;

  function automatic op_t classify(req_t r);
    op_t o;
    o.code = OP_NOP;
    o.kind = KIND_ROUND;
    if (r.mode) begin
      o.code = OP_END;
    end else begin
      case (r.character)
        CH_LROUND: begin
          o.code = OP_PUSH;
          o.kind = KIND_ROUND;
        end
        CH_LSQUARE: begin
          o.code = OP_PUSH;
          o.kind = KIND_SQUARE;
        end
        CH_LCURLY: begin
          o.code = OP_PUSH;
          o.kind = KIND_CURLY;
        end
        CH_RROUND: begin
          o.code = OP_POP;
          o.kind = KIND_ROUND;
        end
        CH_RSQUARE: begin
          o.code = OP_POP;
          o.kind = KIND_SQUARE;
        end
        CH_RCURLY: begin
          o.code = OP_POP;
          o.kind = KIND_CURLY;
        end
        default: begin
          o.code = OP_NOP;
        end
      endcase
    end
    return o;
  endfunction

endpackage

@@ sv/bbc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/bbc_front.sv @@
// Front stage: takes requests and classifies each byte into a stack operation.
module bbc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bbc_pkg::req_t req,
  output logic          op_valid,
  input  logic          op_ready,
  output bbc_pkg::op_t  op
);

  logic         valid;
  bbc_pkg::op_t held;
  logic         done;

  assign done      = (held.code == bbc_pkg::OP_NOP) || op_ready;
  assign req_ready = !valid || done;
  assign op_valid  = valid && (held.code != bbc_pkg::OP_NOP);
  assign op        = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (req_ready) begin
      valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      held <= bbc_pkg::classify(req);
    end
  end

endmodule

@@ sv/bbc_queue.sv @@
// Short queue of stack operations between the front and back stages.
`include "assert_macros.svh"
module bbc_queue #(
  parameter int DEPTH = bbc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  bbc_pkg::op_t wr_op,
  output logic         rd_valid,
  input  logic         rd_ready,
  output bbc_pkg::op_t rd_op
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bbc_pkg::op_t  slots [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_op    = slots[rptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wr_op;
    end
  end

  `ASSERT_AT(a_count_bound, count <= CW'(DEPTH))
  `ASSERT_AT(a_ptr_gap, (count == '0) |-> (wptr == rptr))

endmodule

@@ sv/bbc_back.sv @@
// Back stage: runs stack operations, latches the first error and reports at each end.
`include "assert_macros.svh"
module bbc_back #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  output logic          op_ready,
  input  bbc_pkg::op_t  op,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bbc_pkg::rsp_t rsp
);

  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [LW-1:0] level;
  logic [LW-1:0] level_next;
  logic [2:0]    err;
  logic [2:0]    err_next;
  logic [1:0]    top;
  logic [1:0]    top_next;
  logic          sec_fwd;
  logic [1:0]    sec_fwd_data;
  logic [1:0]    second;
  logic [1:0]    ram_rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [LW-1:0] level_m1;
  logic [LW-1:0] level_m2;
  logic          take;
  logic          emit;
  logic [2:0]    status;

  assign take     = op_valid && (op.code != bbc_pkg::OP_END || !rsp_valid || rsp_ready);
  assign op_ready = take;
  assign second   = sec_fwd ? sec_fwd_data : ram_rdata;
  assign level_m1 = level - 1'b1;
  assign level_m2 = level_next - LW'(2);
  assign waddr    = level_m1[AW-1:0];
  assign raddr    = (level_next >= LW'(2)) ? level_m2[AW-1:0] : '0;

  always_comb begin
    level_next = level;
    err_next   = err;
    top_next   = top;
    we         = 1'b0;
    emit       = 1'b0;
    status     = bbc_pkg::ST_OK;
    if (take) begin
      case (op.code)
        bbc_pkg::OP_PUSH: begin
          if (err == bbc_pkg::ST_OK) begin
            if (level == LW'(STACK_DEPTH)) begin
              err_next = bbc_pkg::ST_OVERFLOW;
            end else begin
              we         = (level != '0);
              top_next   = op.kind;
              level_next = level + 1'b1;
            end
          end
        end
        bbc_pkg::OP_POP: begin
          if (err == bbc_pkg::ST_OK) begin
            if (level == '0) begin
              err_next = bbc_pkg::ST_EMPTY;
            end else begin
              level_next = level_m1;
              top_next   = second;
              if (top != op.kind) begin
                err_next = bbc_pkg::ST_MISMATCH;
              end
            end
          end
        end
        bbc_pkg::OP_END: begin
          emit = 1'b1;
          if (err != bbc_pkg::ST_OK) begin
            status = err;
          end else if (level != '0) begin
            status = bbc_pkg::ST_UNCLOSED;
          end
          level_next = '0;
          err_next   = bbc_pkg::ST_OK;
        end
        default: begin
          level_next = level;
        end
      endcase
    end
  end

  // The entry just below the top of stack is prefetched from the RAM every cycle.
  bbc_ram #(
    .WIDTH(2),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(top),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      level     <= '0;
      err       <= bbc_pkg::ST_OK;
      rsp_valid <= 1'b0;
      sec_fwd   <= 1'b0;
    end else begin
      level   <= level_next;
      err     <= err_next;
      sec_fwd <= we && (waddr == raddr);
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top          <= top_next;
    sec_fwd_data <= top;
    if (emit) begin
      rsp.expression_valid <= (status == bbc_pkg::ST_OK);
      rsp.status           <= status;
    end
  end

  `ASSERT_AT(a_level_bound, level <= LW'(STACK_DEPTH))
  `ASSERT_AT(a_err_freeze, (op.code != bbc_pkg::OP_END && err != bbc_pkg::ST_OK) |=> $stable(level))
  `ASSERT_NEVER(a_emit_blocked, emit && rsp_valid && !rsp_ready)

endmodule

@@ sv/bracket_balance_checker.sv @@
// Top level of the bracket balance checker: front, operation queue and stack back end.
//
//   channel   direction   handshake                payload
//   request   in          req_valid / req_ready    req  (mode, character)
//   response  out         rsp_valid / rsp_ready    rsp  (expression_valid, status)
//
// One request is taken per cycle unless a full queue stalls the front; the queue holds each operation.
// The back end does one push or pop per cycle as it leaves the queue, using a top-of-stack
// register and a prefetched RAM read of the entry below it.
// A response is registered in the back end once its end request has passed the front and the queue,
// and waits there until rsp_ready takes it; later pushes and pops keep flowing, but a later end waits.
// Reset is synchronous and clears the stack level, the latched error and all valid flags.
module bracket_balance_checker #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF,
  parameter int QUEUE_DEPTH = bbc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bbc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bbc_pkg::rsp_t rsp
);

  logic         f_valid;
  logic         f_ready;
  bbc_pkg::op_t f_op;
  logic         b_valid;
  logic         b_ready;
  bbc_pkg::op_t b_op;

  bbc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .op_valid (f_valid),
    .op_ready (f_ready),
    .op       (f_op)
  );

  bbc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(f_valid),
    .wr_ready(f_ready),
    .wr_op   (f_op),
    .rd_valid(b_valid),
    .rd_ready(b_ready),
    .rd_op   (b_op)
  );

  bbc_back #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (b_valid),
    .op_ready (b_ready),
    .op       (b_op),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

endmodule
